>>> src/cai_pkg.sv
// shared types, constants and helpers of the circular arc interpolator
package cai_pkg;

	localparam int COORD_BITS = 24;
	localparam int DELAY_BITS = 16;
	localparam int POS_BITS   = COORD_BITS + 2;
	localparam int LIM_BITS   = COORD_BITS + 5;
	localparam int DEV_BITS   = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [POS_BITS-1:0]   pos_t;
	typedef logic [LIM_BITS-1:0]          lim_t;
	typedef logic [DELAY_BITS-1:0]        delay_t;
	typedef logic [DEV_BITS-1:0]          dev_t;

	typedef struct packed {
		logic   cmd;
		coord_t start_x;
		coord_t start_y;
		coord_t center_off_i;
		coord_t center_off_j;
		coord_t end_x;
		coord_t end_y;
		logic   clockwise;
		delay_t step_delay;
	} req_t;

	typedef struct packed {
		logic step_taken;
		logic axis;
		logic direction;
		logic last;
		logic limit_hit;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic count_down;
		logic iterate;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;
		logic wait_zero;
	} dp_status_t;

	function automatic pos_t sext_pos(coord_t v);
		return POS_BITS'(v);
	endfunction

endpackage

>>> src/cai_req_if.sv
// request channel: arc loads and time ticks
interface cai_req_if;
	logic          valid;
	logic          ready;
	cai_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/cai_rsp_if.sv
// response channel: one item per iteration
interface cai_rsp_if;
	logic          valid;
	logic          ready;
	cai_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/cai_ctrl.sv
// controller: handshake, command decode and output buffer state
module cai_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_cmd,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cai_pkg::dp_status_t status,
	output cai_pkg::dp_cmd_t    dp_cmd
);
	import cai_pkg::*;

	typedef enum logic {
		S_EMPTY,
		S_FULL
	} state_t;

	state_t state_q;
	logic   accept;
	logic   tick;

	assign in_ready  = (state_q == S_EMPTY) || out_ready;
	assign out_valid = (state_q == S_FULL);
	assign accept    = in_valid && in_ready;
	assign tick      = accept && (in_cmd == CMD_TICK) && status.busy;

	always_comb begin
		dp_cmd.load       = accept && (in_cmd == CMD_LOAD);
		dp_cmd.count_down = tick && !status.wait_zero;
		dp_cmd.iterate    = tick && status.wait_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else begin
			case (state_q)
				S_EMPTY: begin
					if (dp_cmd.iterate) state_q <= S_FULL;
				end
				S_FULL: begin
					if (dp_cmd.iterate) state_q <= S_FULL;
					else if (out_ready) state_q <= S_EMPTY;
				end
				default: state_q <= S_EMPTY;
			endcase
		end
	end
endmodule

>>> src/cai_datapath.sv
// datapath: arc state, quadrant step choice and deviation update
module cai_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cai_pkg::dp_cmd_t    dp_cmd,
	input  cai_pkg::req_t       req,
	output cai_pkg::dp_status_t status,
	output cai_pkg::rsp_t       res
);
	import cai_pkg::*;

	pos_t   rel_x_q, rel_y_q, target_x_q, target_y_q;
	dev_t   dev_q;
	lim_t   count_q, limit_q;
	delay_t wait_q, delay_q;
	logic   cw_q;
	logic   busy_q;
	rsp_t   res_q;

	// load arithmetic
	pos_t                  ci, cj;
	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS:0]   mx, my;
	logic [COORD_BITS+1:0] msum;
	lim_t                  limit_new;

	always_comb begin
		ci        = sext_pos(req.center_off_i);
		cj        = sext_pos(req.center_off_j);
		dx        = (COORD_BITS+1)'(req.end_x) - (COORD_BITS+1)'(req.start_x);
		dy        = (COORD_BITS+1)'(req.end_y) - (COORD_BITS+1)'(req.start_y);
		mx        = dx[COORD_BITS] ? -dx : dx;
		my        = dy[COORD_BITS] ? -dy : dy;
		msum      = {1'b0, mx} + {1'b0, my};
		limit_new = LIM_BITS'({msum, 1'b0});
	end

	// one iteration
	logic x_zero, y_zero, x_neg, y_neg, fpos;
	logic moved, ax, up;
	pos_t c, c_next, nx, ny;
	dev_t twice, dev_next;
	lim_t count_next;
	logic at_end, fin;

	always_comb begin
		x_zero = (rel_x_q == '0);
		y_zero = (rel_y_q == '0);
		x_neg  = rel_x_q[POS_BITS-1];
		y_neg  = rel_y_q[POS_BITS-1];
		fpos   = !dev_q[DEV_BITS-1];
		moved  = 1'b1;
		ax     = AXIS_X;
		up     = 1'b0;
		if (!x_neg && !x_zero && !y_neg) begin
			// first quadrant
			if (cw_q) begin ax = fpos ? AXIS_Y : AXIS_X; up = !fpos; end
			else      begin ax = fpos ? AXIS_X : AXIS_Y; up = !fpos; end
		end else if ((x_neg || x_zero) && !y_neg && !y_zero) begin
			// second quadrant
			if (cw_q) begin ax = fpos ? AXIS_X : AXIS_Y; up = 1'b1; end
			else      begin ax = fpos ? AXIS_Y : AXIS_X; up = 1'b0; end
		end else if (x_neg && (y_neg || y_zero)) begin
			// third quadrant
			if (cw_q) begin ax = fpos ? AXIS_Y : AXIS_X; up = fpos; end
			else      begin ax = fpos ? AXIS_X : AXIS_Y; up = fpos; end
		end else if (!x_neg && y_neg) begin
			// fourth quadrant
			if (cw_q) begin ax = fpos ? AXIS_X : AXIS_Y; up = 1'b0; end
			else      begin ax = fpos ? AXIS_Y : AXIS_X; up = 1'b1; end
		end else begin
			// at the center
			moved = 1'b0;
		end

		c        = (ax == AXIS_Y) ? rel_y_q : rel_x_q;
		twice    = DEV_BITS'(c) << 1;
		dev_next = up ? (dev_q + twice + DEV_BITS'(1)) : (dev_q - twice + DEV_BITS'(1));
		c_next   = up ? (c + POS_BITS'(1)) : (c - POS_BITS'(1));
		nx       = (moved && ax == AXIS_X) ? c_next : rel_x_q;
		ny       = (moved && ax == AXIS_Y) ? c_next : rel_y_q;

		count_next = count_q + LIM_BITS'(1);
		at_end     = (nx == target_x_q) && (ny == target_y_q);
		fin        = at_end || (count_next >= limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_x_q    <= '0;
			rel_y_q    <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			dev_q      <= '0;
			count_q    <= '0;
			limit_q    <= '0;
			wait_q     <= '0;
			delay_q    <= '0;
			cw_q       <= 1'b0;
			busy_q     <= 1'b0;
		end else if (dp_cmd.load) begin
			rel_x_q    <= -ci;
			rel_y_q    <= -cj;
			target_x_q <= sext_pos(req.end_x) - sext_pos(req.start_x) - ci;
			target_y_q <= sext_pos(req.end_y) - sext_pos(req.start_y) - cj;
			dev_q      <= '0;
			count_q    <= '0;
			limit_q    <= limit_new;
			wait_q     <= '0;
			delay_q    <= req.step_delay;
			cw_q       <= req.clockwise;
			busy_q     <= (limit_new != '0);
		end else if (dp_cmd.count_down) begin
			wait_q <= wait_q - DELAY_BITS'(1);
		end else if (dp_cmd.iterate) begin
			if (moved) dev_q <= dev_next;
			rel_x_q <= nx;
			rel_y_q <= ny;
			count_q <= count_next;
			busy_q  <= !fin;
			if (!fin) wait_q <= delay_q;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.iterate) begin
			res_q.step_taken <= moved;
			res_q.axis       <= moved && (ax == AXIS_Y);
			res_q.direction  <= moved && up;
			res_q.last       <= fin;
			res_q.limit_hit  <= fin && !at_end;
		end
	end

	assign status.busy      = busy_q;
	assign status.wait_zero = (wait_q == '0);
	assign res              = res_q;
endmodule

>>> src/circular_arc_interpolator_core.sv
// top level of the point-by-point comparison circular interpolator
// a tick item that runs an iteration gives its result item from the output register in the next cycle
// throughput: one item per cycle; loads, idle ticks and wait ticks give no result
// the single output register is refilled in the cycle it is emptied, so only a stalled
// consumer holding a pending result stops new items
// reset (arst_n low, asynchronous): idle, no arc loaded, output register empty
module circular_arc_interpolator_core (
	input logic  clk,
	input logic  arst_n,
	cai_req_if.sink   req,
	cai_rsp_if.source rsp
);
	import cai_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t    dp_cmd;
	dp_status_t status;

	// controller: accepts an item whenever the result register is free or being drained,
	// turns a tick during an active arc into a wait count down or an iteration depending on datapath status
	cai_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_cmd    (req.data.cmd),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.dp_cmd    (dp_cmd)
	);

	// datapath: position relative to center, deviation, iteration and wait counters;
	// one iteration (quadrant choice, deviation add, end check) is combinational and registered on an iterate command
	cai_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.dp_cmd (dp_cmd),
		.req    (req.data),
		.status (status),
		.res    (rsp.data)
	);
endmodule
